@@ sv/nqst_pkg.sv @@
// shared types, constants and lookup tables for the note queue tone player
`default_nettype none

package nqst_pkg;

  // register and field widths
  localparam int CC_W   = 27;
  localparam int TPM_W  = 17;
  localparam int FREQ_W = 13;
  localparam int LVL_W  = 8;
  localparam int MS_W   = 12;
  localparam int FILL_W = 4;
  localparam int VOL_W  = 4;
  localparam int NOTE_W = 7;
  localparam int DUR_W  = 8;

  // parameter defaults
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int WAVE_STEPS_DEF  = 16;
  localparam int NOTE_COUNT_DEF  = 89;

  // reset values and limits
  localparam logic [CC_W-1:0]  CORE_CLOCK_RESET   = CC_W'(48000000);
  localparam logic [TPM_W-1:0] TICKS_PER_MS_RESET = TPM_W'(48000);
  localparam logic [CC_W-1:0]  TONE_PERIOD_RESET  = CC_W'(48000000 / 100000 - 1);
  localparam logic [11:0]      SILENCE_LEVEL      = 12'd2048;
  localparam logic [DUR_W-1:0] MAX_DURATION       = 8'd250;
  localparam logic [7:0]       MAX_FILL           = 8'd15;
  localparam logic [7:0]       MAX_VOLUME         = 8'd15;
  localparam logic [MS_W-1:0]  DURATION_UNIT_MS   = 12'd10;

  // register index, taken from byte address bit 2
  localparam logic REG_CORE_CLOCK   = 1'b0;
  localparam logic REG_TICKS_PER_MS = 1'b1;

  // command codes
  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_PLAY  = 3'd1,
    CMD_PAUSE = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIVIDE
  } state_t;

  // one queue entry
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [DUR_W-1:0]  dur;
    logic [FILL_W-1:0] fill;
    logic [VOL_W-1:0]  vol;
  } note_entry_t;

  // tone frequency in hz per note number, past the table plays the top note
  function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] idx);
    logic [FREQ_W-1:0] f;
    case (idx)
      7'd0:  f = 13'd20;   7'd1:  f = 13'd27;   7'd2:  f = 13'd29;   7'd3:  f = 13'd31;
      7'd4:  f = 13'd33;   7'd5:  f = 13'd35;   7'd6:  f = 13'd37;   7'd7:  f = 13'd39;
      7'd8:  f = 13'd41;   7'd9:  f = 13'd44;   7'd10: f = 13'd46;   7'd11: f = 13'd49;
      7'd12: f = 13'd52;   7'd13: f = 13'd55;   7'd14: f = 13'd58;   7'd15: f = 13'd62;
      7'd16: f = 13'd65;   7'd17: f = 13'd69;   7'd18: f = 13'd73;   7'd19: f = 13'd78;
      7'd20: f = 13'd82;   7'd21: f = 13'd87;   7'd22: f = 13'd93;   7'd23: f = 13'd98;
      7'd24: f = 13'd104;  7'd25: f = 13'd110;  7'd26: f = 13'd117;  7'd27: f = 13'd123;
      7'd28: f = 13'd131;  7'd29: f = 13'd139;  7'd30: f = 13'd147;  7'd31: f = 13'd156;
      7'd32: f = 13'd165;  7'd33: f = 13'd175;  7'd34: f = 13'd185;  7'd35: f = 13'd196;
      7'd36: f = 13'd208;  7'd37: f = 13'd220;  7'd38: f = 13'd233;  7'd39: f = 13'd247;
      7'd40: f = 13'd262;  7'd41: f = 13'd277;  7'd42: f = 13'd294;  7'd43: f = 13'd311;
      7'd44: f = 13'd330;  7'd45: f = 13'd349;  7'd46: f = 13'd370;  7'd47: f = 13'd392;
      7'd48: f = 13'd415;  7'd49: f = 13'd440;  7'd50: f = 13'd466;  7'd51: f = 13'd494;
      7'd52: f = 13'd523;  7'd53: f = 13'd554;  7'd54: f = 13'd587;  7'd55: f = 13'd622;
      7'd56: f = 13'd659;  7'd57: f = 13'd698;  7'd58: f = 13'd740;  7'd59: f = 13'd784;
      7'd60: f = 13'd831;  7'd61: f = 13'd880;  7'd62: f = 13'd932;  7'd63: f = 13'd988;
      7'd64: f = 13'd1047; 7'd65: f = 13'd1109; 7'd66: f = 13'd1175; 7'd67: f = 13'd1245;
      7'd68: f = 13'd1319; 7'd69: f = 13'd1397; 7'd70: f = 13'd1480; 7'd71: f = 13'd1568;
      7'd72: f = 13'd1661; 7'd73: f = 13'd1760; 7'd74: f = 13'd1865; 7'd75: f = 13'd1976;
      7'd76: f = 13'd2093; 7'd77: f = 13'd2217; 7'd78: f = 13'd2349; 7'd79: f = 13'd2489;
      7'd80: f = 13'd2637; 7'd81: f = 13'd2794; 7'd82: f = 13'd2960; 7'd83: f = 13'd3136;
      7'd84: f = 13'd3322; 7'd85: f = 13'd3520; 7'd86: f = 13'd3729; 7'd87: f = 13'd3951;
      default: f = 13'd4186;
    endcase
    return f;
  endfunction

  // swing around silence: floor(2047 * volume / 150)
  function automatic logic [LVL_W-1:0] vol_swing(input logic [VOL_W-1:0] v);
    logic [LVL_W-1:0] s;
    case (v)
      4'd0:  s = 8'd0;   4'd1:  s = 8'd13;  4'd2:  s = 8'd27;  4'd3:  s = 8'd40;
      4'd4:  s = 8'd54;  4'd5:  s = 8'd68;  4'd6:  s = 8'd81;  4'd7:  s = 8'd95;
      4'd8:  s = 8'd109; 4'd9:  s = 8'd122; 4'd10: s = 8'd136; 4'd11: s = 8'd150;
      4'd12: s = 8'd163; 4'd13: s = 8'd177; 4'd14: s = 8'd191;
      default: s = 8'd204;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/nqst_ram.sv @@
// generic single-port-write, registered-read ram
`default_nettype none

module nqst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/nqst_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none

module nqst_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 18
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output logic                  valid
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W:0]   diff;

  // trial subtraction of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, work[NUM_W-1]};
    ge      = shifted >= {1'b0, den};
    diff    = shifted - {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      valid   <= 1'b0;
      cnt     <= '0;
    end else begin
      valid <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          valid   <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      rem  <= '0;
    end else if (running) begin
      rem  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      work <= {work[NUM_W-2:0], ge};
    end
  end

  assign quo = work;

endmodule

`default_nettype wire

@@ sv/note_queue_square_tone_player_unit.sv @@
// top level of the note queue square tone player
`default_nettype none

// Square-wave tone player with a note queue held in a small ram. Commands (add note,
// play, pause, clear, clock tick) are taken when start is high and busy is low; the
// result (dac_level, is_playing, free_slots, note_taken) shows for one cycle with done
// high, and the receiver cannot hold it off. Ticks and all other requests that load no
// note answer in the cycle after the request, back to back. Loading a note (play from
// stop, or a tick that ends a note, with a note queued) holds busy through the
// queue ram read, then the bit-serial divider that turns the core clock into the tone step
// period, then the result. Configuration goes over an apb-style port at byte addresses
// 0 (core_clock_hz) and 4 (ticks_per_ms); a new core clock is used from the next note
// load on.
module note_queue_square_tone_player_unit
  import nqst_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int WAVE_STEPS  = WAVE_STEPS_DEF,
  parameter int NOTE_COUNT  = NOTE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  func,
  input  wire logic [6:0]  note_index,
  input  wire logic [7:0]  duration,
  input  wire logic [7:0]  duty_fill,
  input  wire logic [7:0]  loudness,
  // result channel
  output logic             done,
  output logic [11:0]      dac_level,
  output logic             is_playing,
  output logic [4:0]       free_slots,
  output logic             note_taken,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int PH_W   = $clog2(WAVE_STEPS);
  localparam int DVSR_W = FREQ_W + $clog2(WAVE_STEPS + 1);
  localparam int ENT_W  = $bits(note_entry_t);

  // configuration registers
  logic [CC_W-1:0]  core_clock_hz;
  logic [TPM_W-1:0] ticks_per_ms;

  // player state
  state_t           state, state_next;
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic             playing;
  logic [11:0]      wave_high, wave_low;
  logic [FILL_W-1:0] cur_fill;
  logic [PH_W-1:0]  wave_phase;
  logic [CC_W-1:0]  tone_period, tone_cnt;
  logic [TPM_W-1:0] ms_pre;
  logic [MS_W-1:0]  note_ms, note_ms_limit;
  logic [11:0]      out_sample;

  // control terms
  cmd_t             cmd;
  logic             accept;
  logic             silent, add_ok, full, q_empty;
  logic [PTR_W:0]   used;
  logic [PTR_W-1:0] rd_ptr_inc, wr_ptr_inc;
  logic [TPM_W-1:0] per_ms;
  logic             tone_hit, ms_hit, note_end;
  logic             want_load, do_clear, start_fetch;
  logic             cfg_wr;

  // queue ram and divider
  note_entry_t      wr_entry, rd_entry;
  logic [ENT_W-1:0] rd_raw;
  logic             ram_we;
  logic [DVSR_W-1:0] divisor;
  logic [CC_W-1:0]  quo;
  logic             div_valid;
  logic [LVL_W-1:0] swing;

  assign cmd    = cmd_t'(func);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  // queue occupancy
  always_comb begin
    if (wr_ptr >= rd_ptr) begin
      used = {1'b0, wr_ptr} - {1'b0, rd_ptr};
    end else begin
      used = {1'b0, wr_ptr} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, rd_ptr};
    end
    full       = used >= (PTR_W+1)'(QUEUE_DEPTH - 1);
    q_empty    = rd_ptr == wr_ptr;
    rd_ptr_inc = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    wr_ptr_inc = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  end

  // add-note checks and the entry that goes into the queue
  always_comb begin
    silent = note_index == '0;
    add_ok = ({1'b0, note_index} < 8'(NOTE_COUNT))
             && (duration != '0) && (duration <= MAX_DURATION)
             && (silent || ((duty_fill != '0) && (duty_fill <= MAX_FILL)
                            && (loudness <= MAX_VOLUME)))
             && !full;
    wr_entry.note = note_index;
    wr_entry.dur  = duration;
    wr_entry.fill = silent ? FILL_W'(1) : duty_fill[FILL_W-1:0];
    wr_entry.vol  = silent ? '0 : loudness[VOL_W-1:0];
    ram_we        = accept && (cmd == CMD_ADD) && add_ok;
  end

  // tick timing: tone step and millisecond timer
  always_comb begin
    per_ms   = (ticks_per_ms == '0) ? TPM_W'(1) : ticks_per_ms;
    tone_hit = tone_cnt >= tone_period;
    ms_hit   = ({1'b0, ms_pre} + (TPM_W+1)'(1)) >= {1'b0, per_ms};
    note_end = ms_hit && (({1'b0, note_ms} + (MS_W+1)'(1)) >= {1'b0, note_ms_limit});
  end

  // note load decisions
  always_comb begin
    want_load   = accept && (((cmd == CMD_PLAY) && !playing)
                             || ((cmd == CMD_TICK) && playing && note_end));
    do_clear    = (accept && (cmd == CMD_CLEAR)) || (want_load && q_empty);
    start_fetch = want_load && !q_empty;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and busy
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start_fetch) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // note queue storage
  nqst_ram #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata(wr_entry),
    .raddr(rd_ptr),
    .rdata(rd_raw)
  );

  assign rd_entry = note_entry_t'(rd_raw);
  assign swing    = vol_swing(rd_entry.vol);
  assign divisor  = DVSR_W'(note_freq(rd_entry.note)) * DVSR_W'(WAVE_STEPS);

  // tone period divider: core clock over frequency times steps
  nqst_div #(
    .NUM_W(CC_W),
    .DEN_W(DVSR_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == ST_FETCH),
    .num  (core_clock_hz),
    .den  (divisor),
    .quo  (quo),
    .valid(div_valid)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock_hz <= CORE_CLOCK_RESET;
      ticks_per_ms  <= TICKS_PER_MS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CORE_CLOCK:   core_clock_hz <= pwdata[CC_W-1:0];
        REG_TICKS_PER_MS: ticks_per_ms  <= pwdata[TPM_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[2])
      REG_CORE_CLOCK:   prdata = 32'(core_clock_hz);
      REG_TICKS_PER_MS: prdata = 32'(ticks_per_ms);
      default:          prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // player state update
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      playing       <= 1'b0;
      wave_high     <= SILENCE_LEVEL;
      wave_low      <= SILENCE_LEVEL;
      cur_fill      <= '0;
      wave_phase    <= '0;
      tone_period   <= TONE_PERIOD_RESET;
      tone_cnt      <= '0;
      ms_pre        <= '0;
      note_ms       <= '0;
      note_ms_limit <= '0;
      out_sample    <= SILENCE_LEVEL;
      done          <= 1'b0;
      note_taken    <= 1'b0;
    end else begin
      done       <= 1'b0;
      note_taken <= 1'b0;

      // add note
      if (ram_we) begin
        wr_ptr     <= wr_ptr_inc;
        note_taken <= 1'b1;
      end

      // pause
      if (accept && (cmd == CMD_PAUSE) && playing) begin
        playing    <= 1'b0;
        out_sample <= SILENCE_LEVEL;
      end

      // tick while playing: tone step, then millisecond timer
      if (accept && (cmd == CMD_TICK) && playing) begin
        if (tone_hit) begin
          tone_cnt   <= '0;
          out_sample <= (32'(wave_phase) < 32'(cur_fill)) ? wave_high : wave_low;
          wave_phase <= (wave_phase == PH_W'(WAVE_STEPS - 1)) ? '0 : wave_phase + 1'b1;
        end else begin
          tone_cnt <= tone_cnt + 1'b1;
        end
        if (ms_hit) begin
          ms_pre <= '0;
          if (!note_end) begin
            note_ms <= note_ms + 1'b1;
          end
        end else begin
          ms_pre <= ms_pre + 1'b1;
        end
      end

      // clear, or a load with nothing queued
      if (do_clear) begin
        playing    <= 1'b0;
        rd_ptr     <= '0;
        wr_ptr     <= '0;
        out_sample <= SILENCE_LEVEL;
      end

      // every request that does not load a note answers at once
      if (accept && !start_fetch) begin
        done <= 1'b1;
      end

      // queue entry arrives: levels, fill, length, counters restart
      if (state == ST_FETCH) begin
        wave_high     <= SILENCE_LEVEL + 12'(swing);
        wave_low      <= SILENCE_LEVEL - 12'(swing);
        cur_fill      <= rd_entry.fill;
        note_ms_limit <= MS_W'(rd_entry.dur) * DURATION_UNIT_MS;
        tone_cnt      <= '0;
        wave_phase    <= '0;
        note_ms       <= '0;
        ms_pre        <= '0;
      end

      // divider finished: note is now playing
      if ((state == ST_DIVIDE) && div_valid) begin
        tone_period <= (quo == '0) ? '0 : quo - 1'b1;
        playing     <= 1'b1;
        rd_ptr      <= rd_ptr_inc;
        done        <= 1'b1;
      end
    end
  end

  // result ports
  assign dac_level  = out_sample;
  assign is_playing = playing;
  assign free_slots = 5'((PTR_W+1)'(QUEUE_DEPTH - 1) - used);

endmodule

`default_nettype wire

@@ sv/nqst_checker.sv @@
// port-level checks for the note queue tone player, bound to the top level
`default_nettype none

module nqst_checker
  import nqst_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  func,
  input wire logic        done,
  input wire logic [11:0] dac_level,
  input wire logic        is_playing,
  input wire logic [4:0]  free_slots,
  input wire logic        note_taken
);

  // a finished note load always answers
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("note load ended without a result");

  // a stored note is reported only with a result
  assert property (@(posedge clk) disable iff (rst) note_taken |-> done)
    else $error("note_taken without done");

  // a stopped player sits at silence
  assert property (@(posedge clk) disable iff (rst) (done && !is_playing)
                   |-> (dac_level == SILENCE_LEVEL))
    else $error("stopped player not at silence");

  // clear answers next cycle with an empty, stopped player
  assert property (@(posedge clk) disable iff (rst)
                   (start && !busy && (func == CMD_CLEAR))
                   |=> (done && !is_playing && (free_slots == 5'(QUEUE_DEPTH - 1))))
    else $error("clear request not answered with an empty player");

  // requests that cannot load a note answer in the next cycle
  assert property (@(posedge clk) disable iff (rst)
                   (start && !busy && (func != CMD_PLAY) && (func != CMD_TICK))
                   |=> done)
    else $error("single-cycle request not answered");

endmodule

bind note_queue_square_tone_player_unit nqst_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_nqst_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .func      (func),
  .done      (done),
  .dac_level (dac_level),
  .is_playing(is_playing),
  .free_slots(free_slots),
  .note_taken(note_taken)
);

`default_nettype wire
